// ===== hdl/kepler_orbit_position_unit_defines.svh =====
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef KEPLER_ORBIT_POSITION_UNIT_DEFINES_SVH
`define KEPLER_ORBIT_POSITION_UNIT_DEFINES_SVH

// same-cycle implication
`define KOP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KOP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/kop_pkg.sv =====
package kop_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN = 34'sd2147483648;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [31:0] RAD_TO_PHASE = 32'sd683565276;

  typedef enum logic [2:0] {
    REG_SMA  = 3'd0,
    REG_ECC  = 3'd1,
    REG_MM   = 3'd2,
    REG_SP   = 3'd3,
    REG_NODE = 3'd4,
    REG_INCL = 3'd5,
    REG_PERI = 3'd6
  } kop_reg_e;

  function automatic logic [31:0] atan_phase(input int unsigned idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/kepler_orbit_position_unit.sv =====
// Kepler orbit position unit.
// Input stream s_axis: one time value per transfer (tdata = time_ticks).
// Output stream m_axis: one position per input (tdata = pos_x, pos_y, pos_z).
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 axis, 1 eccentricity, 2 mean motion, 3 start phase, 4 node,
//   5 inclination, 6 periapsis); write only with no transfer in flight.
// Throughput is one item per cycle while the skid register is empty. There are
// five pipelined 30-step CORDIC units (mean and eccentric anomaly, three rotation
// angles); items pass the anomaly units and a six-stage multiply and rotate chain.
// The rotation sines and a*sqrt(1-e^2) come from the registers alone; the
// square root runs bit-serially after an eccentricity write and settles before
// an item that follows the write reaches the multiply and rotate chain.
// Reset clears the config registers to zero and empties the pipeline.
// When the receiver stalls, a skid register takes one more result and then
// s_axis_tready drops; the whole pipeline holds until the skid drains.
`include "kepler_orbit_position_unit_defines.svh"

module kepler_orbit_position_unit import kop_pkg::*; #(
  parameter int ANGLE_BITS = 32,
  parameter int COORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] time_ticks
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [((3*COORD_BITS+7)/8)*8-1:0] m_axis_tdata  // pos_x, pos_y, pos_z
);

  localparam int OUT_W = ((3*COORD_BITS+7)/8)*8;
  localparam int PW    = 3*COORD_BITS;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_BITS-1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  // config registers
  logic [29:0] sma_q;
  logic [15:0] ecc_q;
  logic [31:0] mm_q, sp_q, node_q, incl_q, peri_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sma_q  <= '0;
      ecc_q  <= '0;
      mm_q   <= '0;
      sp_q   <= '0;
      node_q <= '0;
      incl_q <= '0;
      peri_q <= '0;
    end else if (cfg_we_i) begin
      case (kop_reg_e'(cfg_idx_i))
        REG_SMA:  sma_q  <= cfg_wdata_i[29:0];
        REG_ECC:  ecc_q  <= cfg_wdata_i[15:0];
        REG_MM:   mm_q   <= cfg_wdata_i;
        REG_SP:   sp_q   <= cfg_wdata_i;
        REG_NODE: node_q <= cfg_wdata_i;
        REG_INCL: incl_q <= cfg_wdata_i;
        REG_PERI: peri_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // b = isqrt((2^32 - e^2) << 28), bit-serial
  logic        sq_start_q, sq_busy_q;
  logic [62:0] sq_v_q, sq_r_q, sq_bit_q;
  logic [62:0] sq_init, sq_sum, sq_r_d;
  logic        sq_ge;
  logic [31:0] e_sq;
  logic [30:0] b_q;
  logic [60:0] ab_q;

  assign e_sq    = ecc_q * ecc_q;
  assign sq_init = (63'd1 << 60) - {3'b000, e_sq, 28'd0};
  assign sq_sum  = sq_r_q + sq_bit_q;
  assign sq_ge   = sq_v_q >= sq_sum;
  assign sq_r_d  = sq_ge ? ((sq_r_q >> 1) + sq_bit_q) : (sq_r_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_start_q <= 1'b0;
      sq_busy_q  <= 1'b0;
      b_q        <= 31'd1 << 30;
    end else begin
      sq_start_q <= cfg_we_i && (kop_reg_e'(cfg_idx_i) == REG_ECC);
      if (sq_start_q) begin
        sq_busy_q <= 1'b1;
      end else if (sq_busy_q && sq_bit_q == 63'd1) begin
        sq_busy_q <= 1'b0;
        b_q       <= sq_r_d[30:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_start_q) begin
      sq_v_q   <= sq_init;
      sq_r_q   <= '0;
      sq_bit_q <= 63'd1 << 62;
    end else if (sq_busy_q) begin
      if (sq_ge) sq_v_q <= sq_v_q - sq_sum;
      sq_r_q   <= sq_r_d;
      sq_bit_q <= sq_bit_q >> 2;
    end
    ab_q <= sma_q * b_q;
  end

  // rotation sines from the registers, free running
  logic signed [31:0] sw, cw, si, ci, sn, cn;

  kop_cordic #(.ANGLE_BITS(ANGLE_BITS), .SIDE_W(1)) u_cordic_peri (
    .clk_i, .rst_ni, .en_i(1'b1), .valid_i(1'b1), .phase_i(peri_q), .side_i(1'b0),
    .valid_o(), .sin_o(sw), .cos_o(cw), .side_o()
  );
  kop_cordic #(.ANGLE_BITS(ANGLE_BITS), .SIDE_W(1)) u_cordic_incl (
    .clk_i, .rst_ni, .en_i(1'b1), .valid_i(1'b1), .phase_i(incl_q), .side_i(1'b0),
    .valid_o(), .sin_o(si), .cos_o(ci), .side_o()
  );
  kop_cordic #(.ANGLE_BITS(ANGLE_BITS), .SIDE_W(1)) u_cordic_node (
    .clk_i, .rst_ni, .en_i(1'b1), .valid_i(1'b1), .phase_i(node_q), .side_i(1'b0),
    .valid_o(), .sin_o(sn), .cos_o(cn), .side_o()
  );

  // item pipeline
  logic en;
  logic sk_vld_q;
  assign en = !sk_vld_q;
  assign s_axis_tready = en;

  logic        va_q;
  logic [31:0] proda_q, m_phase;
  assign m_phase = proda_q + sp_q;

  always_ff @(posedge clk_i) begin
    if (en) proda_q <= mm_q * s_axis_tdata;
  end

  logic               vm;
  logic signed [31:0] sm;
  logic [31:0]        mm_side;

  kop_cordic #(.ANGLE_BITS(ANGLE_BITS), .SIDE_W(32)) u_cordic_m (
    .clk_i, .rst_ni, .en_i(en), .valid_i(va_q), .phase_i(m_phase), .side_i(m_phase),
    .valid_o(vm), .sin_o(sm), .cos_o(), .side_o(mm_side)
  );

  logic               vc1_q, vc2_q;
  logic signed [48:0] p1_d, p1_q;
  logic signed [32:0] p1s;
  logic signed [63:0] p2_d, p2_q;
  logic [31:0]        m1_q, m2_q, e_phase;

  assign p1_d    = $signed({1'b0, ecc_q}) * sm;
  assign p1s     = p1_q[48:16];
  assign p2_d    = p1s * RAD_TO_PHASE;
  assign e_phase = m2_q + p2_q[61:30];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
      m1_q <= mm_side;
      p2_q <= p2_d;
      m2_q <= m1_q;
    end
  end

  logic               ve;
  logic signed [31:0] se, ce;

  kop_cordic #(.ANGLE_BITS(ANGLE_BITS), .SIDE_W(1)) u_cordic_e (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vc2_q), .phase_i(e_phase), .side_i(1'b0),
    .valid_o(ve), .sin_o(se), .cos_o(ce), .side_o()
  );

  // plane point and rotation
  logic               vd1_q, vd2_q, vd3_q, vd4_q, vd5_q, vd6_q;
  logic signed [32:0] cdiff;
  logic signed [63:0] xp_q, yp_q;
  logic signed [35:0] xv, yv;
  logic signed [67:0] xcw_q, ysw_q, xsw_q, ycw_q;
  logic signed [67:0] d3a, d3b;
  logic signed [35:0] x1_q, y1_q, x1b_q;
  logic signed [67:0] y2p_q, z2p_q;
  logic signed [35:0] y2v, z2v, z2_q;
  logic signed [67:0] xcn_q, ysn_q, xsn_q, ycn_q;
  logic signed [67:0] d6a, d6b;
  logic [COORD_BITS-1:0] px_q, py_q, pz_q;

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [36:0] v);
    logic signed [63:0] w;
    logic signed [63:0] r;
    w = {{27{v[36]}}, v};
    r = w;
    if (w > SAT_HI) r = SAT_HI;
    if (w < SAT_LO) r = SAT_LO;
    return r[COORD_BITS-1:0];
  endfunction

  assign cdiff = $signed({ce[31], ce}) - $signed({3'b000, ecc_q, 14'd0});
  assign xv    = {{2{xp_q[63]}}, xp_q[63:30]};
  assign yv    = {{2{yp_q[63]}}, yp_q[63:30]};
  assign d3a   = xcw_q - ysw_q;
  assign d3b   = xsw_q + ycw_q;
  assign y2v   = y2p_q[65:30];
  assign z2v   = z2p_q[65:30];
  assign d6a   = xcn_q - ysn_q;
  assign d6b   = xsn_q + ycn_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xp_q  <= $signed({1'b0, sma_q}) * cdiff;
      yp_q  <= $signed({1'b0, ab_q[60:30]}) * se;
      xcw_q <= xv * cw;
      ysw_q <= yv * sw;
      xsw_q <= xv * sw;
      ycw_q <= yv * cw;
      x1_q  <= d3a[65:30];
      y1_q  <= d3b[65:30];
      y2p_q <= y1_q * ci;
      z2p_q <= y1_q * si;
      x1b_q <= x1_q;
      xcn_q <= x1b_q * cn;
      ysn_q <= y2v * sn;
      xsn_q <= x1b_q * sn;
      ycn_q <= y2v * cn;
      z2_q  <= z2v;
      px_q  <= sat_coord(d6a[66:30]);
      py_q  <= sat_coord(d6b[66:30]);
      pz_q  <= sat_coord({z2_q[35], z2_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      vc1_q <= 1'b0;
      vc2_q <= 1'b0;
      vd1_q <= 1'b0;
      vd2_q <= 1'b0;
      vd3_q <= 1'b0;
      vd4_q <= 1'b0;
      vd5_q <= 1'b0;
      vd6_q <= 1'b0;
    end else if (en) begin
      va_q  <= s_axis_tvalid;
      vc1_q <= vm;
      vc2_q <= vc1_q;
      vd1_q <= ve;
      vd2_q <= vd1_q;
      vd3_q <= vd2_q;
      vd4_q <= vd3_q;
      vd5_q <= vd4_q;
      vd6_q <= vd5_q;
    end
  end

  // output register and skid
  logic          out_vld_q;
  logic [PW-1:0] out_data_q, sk_data_q, pd;
  logic          out_take, arr;

  assign pd       = {pz_q, py_q, px_q};
  assign out_take = !out_vld_q || m_axis_tready;
  assign arr      = en && vd6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sk_vld_q  <= 1'b0;
    end else if (out_take) begin
      if (sk_vld_q) begin
        out_vld_q <= 1'b1;
        sk_vld_q  <= 1'b0;
      end else begin
        out_vld_q <= arr;
      end
    end else if (arr) begin
      sk_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_data_q <= sk_vld_q ? sk_data_q : pd;
    end else if (arr) begin
      sk_data_q <= pd;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'(out_data_q);

  `KOP_ASSERT_NOW(a_sqrt_settled, en && ve, !sq_busy_q && !sq_start_q, "sqrt busy at use")
  `KOP_ASSERT_NOW(a_skid_needs_out, sk_vld_q, out_vld_q, "skid full with empty output")
  `KOP_ASSERT_NEXT(a_skid_fill, arr && out_vld_q && !m_axis_tready, sk_vld_q, "result lost")
  `KOP_ASSERT_NOW(a_b_range, !sq_busy_q, b_q <= (31'd1 << 30), "sqrt result out of range")

endmodule

// ===== hdl/kop_cordic.sv =====
module kop_cordic import kop_pkg::*; #(
  parameter int ANGLE_BITS = 32,
  parameter int SIDE_W     = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [31:0]         phase_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic signed [31:0]  sin_o,
  output logic signed [31:0]  cos_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int NS = CORDIC_STEPS;
  localparam logic [31:0] DROP = (32'd1 << (32 - ANGLE_BITS)) - 32'd1;

  logic [31:0]        p;
  logic signed [33:0] zin, zf;
  logic               fl;

  logic signed [33:0] x_q [NS+1];
  logic signed [33:0] y_q [NS+1];
  logic signed [33:0] z_q [NS+1];
  logic               flip_q [NS+1];
  logic [SIDE_W-1:0]  side_q [NS+1];
  logic [NS+1:0]      vld_q;

  logic signed [33:0] xf, yf;
  logic signed [31:0] sin_q, cos_q;
  logic [SIDE_W-1:0]  side_out_q;

  // fold into [-1/4, +1/4] turn
  always_comb begin
    p   = phase_i & ~DROP;
    zin = {{2{p[31]}}, p};
    zf  = zin;
    fl  = 1'b0;
    if (zin > ONE_Q30) begin
      zf = zin - HALF_TURN;
      fl = 1'b1;
    end else if (zin < -ONE_Q30) begin
      zf = zin + HALF_TURN;
      fl = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0]    <= zf;
      flip_q[0] <= fl;
      x_q[0]    <= CORDIC_GAIN;
      y_q[0]    <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic signed [33:0] dx, dy, at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = $signed({2'b00, atan_phase(i)});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][33]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
        flip_q[i+1] <= flip_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  always_comb begin
    xf = flip_q[NS] ? -x_q[NS] : x_q[NS];
    yf = flip_q[NS] ? -y_q[NS] : y_q[NS];
    if (xf > ONE_Q30) xf = ONE_Q30;
    if (xf < -ONE_Q30) xf = -ONE_Q30;
    if (yf > ONE_Q30) yf = ONE_Q30;
    if (yf < -ONE_Q30) yf = -ONE_Q30;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q      <= xf[31:0];
      sin_q      <= yf[31:0];
      side_out_q <= side_q[NS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS:0], valid_i};
    end
  end

  assign valid_o = vld_q[NS+1];
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;
  assign side_o  = side_out_q;

endmodule
